@@ rtl/mandelbrot_escape_time_defines.svh @@
// assertion macros for the mandelbrot escape-time block
// used by rtl files that carry assertions; expects aclk and aresetn in scope
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`ifndef SYNTHESIS
`define MET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define MET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define MET_ASSERT(lbl, prop, msg)
`define MET_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/met_pkg.sv @@
// shared types, constants and helper functions of the mandelbrot escape-time block
// no dependencies; imported by every module of the block
package met_pkg;

    localparam int CoordBits   = 32;
    localparam int IterBits    = 16;
    localparam int FracBits    = 28;
    localparam int ProdBits    = 2 * CoordBits;
    localparam int SatBits     = ProdBits - (FracBits - 1);
    localparam int WideBits    = 48;
    localparam int PixBits     = 12;
    localparam int SizeBits    = 13;
    localparam int DiffBits    = PixBits + 1;
    localparam int StepBits    = 31;
    localparam int HueBits     = 8;
    localparam int IdxBits     = 3;
    localparam int CfgDataBits = 32;

    localparam logic [HueBits-1:0] HueMod = 8'd255;

    localparam logic [SizeBits-1:0]  ResetImageWidth   = 13'd640;
    localparam logic [SizeBits-1:0]  ResetImageHeight  = 13'd480;
    localparam logic [StepBits-1:0]  ResetPixelStep    = 31'd268435;
    localparam logic [CoordBits-1:0] ResetCenter       = '0;
    localparam logic [IterBits-1:0]  ResetIterMax      = 16'd255;
    localparam logic [31:0]          ResetEscapeRadius = 32'd1073741824;

    typedef enum logic [IdxBits-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_PIXEL_STEP    = 3'd2,
        CFG_CENTER_X      = 3'd3,
        CFG_CENTER_Y      = 3'd4,
        CFG_ITER_MAX      = 3'd5,
        CFG_ESCAPE_RADIUS = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_RAW,
        MUL_SQR,
        MUL_DBL
    } mul_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_X,
        ST_MAP_Y,
        ST_SQ_X0,
        ST_SQ_Y0,
        ST_XY,
        ST_UPD,
        ST_SQX,
        ST_SQY,
        ST_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [PixBits-1:0] pixel_x;
        logic [PixBits-1:0] pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [IterBits-1:0] iterations;
        logic                escaped;
        logic [HueBits-1:0]  hue;
    } out_item_t;

    typedef struct packed {
        logic [SizeBits-1:0]         image_width;
        logic [SizeBits-1:0]         image_height;
        logic [StepBits-1:0]         pixel_step;
        logic signed [CoordBits-1:0] center_x;
        logic signed [CoordBits-1:0] center_y;
        logic [IterBits-1:0]         iter_max;
        logic [31:0]                 escape_radius;
    } cfg_t;

    typedef struct packed {
        logic signed [CoordBits-1:0] op_a;
        logic signed [CoordBits-1:0] op_b;
        mul_mode_t                   mode;
    } mul_req_t;

    function automatic logic signed [WideBits-1:0] sext_wide(
        input logic signed [CoordBits-1:0] v
    );
        return {{(WideBits-CoordBits){v[CoordBits-1]}}, v};
    endfunction

    // clamp to the signed coordinate range
    function automatic logic signed [CoordBits-1:0] sat_wide(
        input logic signed [WideBits-1:0] v
    );
        logic signed [WideBits-1:0]  hi;
        logic signed [WideBits-1:0]  lo;
        logic signed [CoordBits-1:0] res;
        hi = sext_wide({1'b0, {(CoordBits-1){1'b1}}});
        lo = sext_wide({1'b1, {(CoordBits-1){1'b0}}});
        if (v > hi) begin
            res = hi[CoordBits-1:0];
        end else if (v < lo) begin
            res = lo[CoordBits-1:0];
        end else begin
            res = v[CoordBits-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/met_cfg.sv @@
// configuration registers of the mandelbrot escape-time block
// depends on met_pkg
module met_cfg import met_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IdxBits-1:0]     cfg_index,
    input  logic [CfgDataBits-1:0] cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[SizeBits-1:0];
                CFG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[SizeBits-1:0];
                CFG_PIXEL_STEP:    cfg_next.pixel_step    = cfg_data[StepBits-1:0];
                CFG_CENTER_X:      cfg_next.center_x      = cfg_data[CoordBits-1:0];
                CFG_CENTER_Y:      cfg_next.center_y      = cfg_data[CoordBits-1:0];
                CFG_ITER_MAX:      cfg_next.iter_max      = cfg_data[IterBits-1:0];
                CFG_ESCAPE_RADIUS: cfg_next.escape_radius = cfg_data[31:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= ResetImageWidth;
            cfg_reg.image_height  <= ResetImageHeight;
            cfg_reg.pixel_step    <= ResetPixelStep;
            cfg_reg.center_x      <= ResetCenter;
            cfg_reg.center_y      <= ResetCenter;
            cfg_reg.iter_max      <= ResetIterMax;
            cfg_reg.escape_radius <= ResetEscapeRadius;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/met_mul.sv @@
// shared sign-magnitude multiplier with registered product and fixed-point saturation
// depends on met_pkg
module met_mul import met_pkg::*; (
    input  logic                        aclk,
    input  mul_req_t                    req,
    output logic [ProdBits-1:0]         prod,
    output logic                        prod_neg,
    output logic signed [CoordBits-1:0] prod_sat
);

    logic [CoordBits-1:0] mag_a;
    logic [CoordBits-1:0] mag_b;
    logic [ProdBits-1:0]  prod_next;
    logic [ProdBits-1:0]  prod_reg;
    logic                 neg_reg;
    mul_mode_t            mode_reg;
    logic [SatBits-1:0]   shifted;
    logic [SatBits-1:0]   lim;
    logic [SatBits-1:0]   mag;

    assign mag_a = req.op_a[CoordBits-1] ? (~req.op_a + 1'b1) : req.op_a;
    assign mag_b = req.op_b[CoordBits-1] ? (~req.op_b + 1'b1) : req.op_b;
    assign prod_next = ProdBits'(mag_a) * ProdBits'(mag_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        neg_reg  <= req.op_a[CoordBits-1] ^ req.op_b[CoordBits-1];
        mode_reg <= req.mode;
    end

    // doubled cross term keeps one more fraction bit
    assign shifted = (mode_reg == MUL_DBL) ? prod_reg[ProdBits-1:FracBits-1]
                                           : {1'b0, prod_reg[ProdBits-1:FracBits]};
    assign lim = neg_reg ? SatBits'({1'b1, {(CoordBits-1){1'b0}}})
                         : SatBits'({1'b0, {(CoordBits-1){1'b1}}});
    assign mag = (shifted > lim) ? lim : shifted;

    assign prod     = prod_reg;
    assign prod_neg = neg_reg;
    assign prod_sat = neg_reg ? (~mag[CoordBits-1:0] + 1'b1) : mag[CoordBits-1:0];

endmodule

@@ rtl/met_ctrl.sv @@
// sequencer and orbit registers of the mandelbrot escape-time block
// depends on met_pkg and mandelbrot_escape_time_defines.svh; drives the shared multiplier
`include "mandelbrot_escape_time_defines.svh"
module met_ctrl import met_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfg_t                        cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  in_item_t                    s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output out_item_t                   m_item,
    output mul_req_t                    mul_req,
    input  logic [ProdBits-1:0]         prod,
    input  logic                        prod_neg,
    input  logic signed [CoordBits-1:0] prod_sat
);

    state_t state_reg, state_next;

    logic signed [DiffBits-1:0]  dx_reg, dx_next;
    logic signed [DiffBits-1:0]  dy_reg, dy_next;
    logic signed [CoordBits-1:0] cx_reg, cx_next;
    logic signed [CoordBits-1:0] cy_reg, cy_next;
    logic signed [CoordBits-1:0] zx_reg, zx_next;
    logic signed [CoordBits-1:0] zy_reg, zy_next;
    logic signed [CoordBits-1:0] sx_reg, sx_next;
    logic signed [CoordBits-1:0] sy_reg, sy_next;
    logic [IterBits-1:0]         iter_reg, iter_next;
    logic [HueBits-1:0]          hue_reg, hue_next;
    logic                        esc_reg, esc_next;
    out_item_t                   m_item_reg, m_item_next;
    logic                        m_valid_reg, m_valid_next;

    logic [WideBits-1:0]         map_mag;
    logic signed [WideBits-1:0]  map_prod;
    logic signed [CoordBits-1:0] map_center;
    logic signed [CoordBits-1:0] map_val;
    logic signed [CoordBits-1:0] diff_sat;
    logic signed [CoordBits-1:0] nx;
    logic signed [CoordBits-1:0] ny;
    logic [CoordBits:0]          mag_sum;
    logic                        escape_hit;
    logic                        at_limit;
    logic                        out_free;
    logic signed [CoordBits-1:0] step_op;

    // mapped coordinate: x product lands in MAP_Y, y product in SQ_X0
    assign map_mag    = prod[WideBits-1:0];
    assign map_prod   = prod_neg ? (~map_mag + 1'b1) : map_mag;
    assign map_center = (state_reg == ST_MAP_Y) ? cfg.center_x : cfg.center_y;
    assign map_val    = sat_wide(map_prod + sext_wide(map_center));

    assign diff_sat = sat_wide(sext_wide(sx_reg) - sext_wide(sy_reg));
    assign nx       = sat_wide(sext_wide(diff_sat) + sext_wide(cx_reg));
    assign ny       = sat_wide(sext_wide(prod_sat) + sext_wide(cy_reg));

    assign mag_sum    = {1'b0, sx_reg} + {1'b0, prod_sat};
    assign escape_hit = mag_sum > {1'b0, cfg.escape_radius};
    assign at_limit   = iter_reg >= cfg.iter_max;
    assign out_free   = !m_valid_reg || m_ready;
    assign step_op    = {1'b0, cfg.pixel_step};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) begin
                state_next = ST_MAP_X;
            end
            ST_MAP_X: state_next = ST_MAP_Y;
            ST_MAP_Y: state_next = ST_SQ_X0;
            ST_SQ_X0: state_next = ST_SQ_Y0;
            ST_SQ_Y0: state_next = ST_XY;
            ST_XY:    state_next = ST_UPD;
            ST_UPD:   state_next = at_limit ? ST_DONE : ST_SQX;
            ST_SQX:   state_next = ST_SQY;
            ST_SQY:   state_next = ST_CHK;
            ST_CHK:   state_next = escape_hit ? ST_DONE : ST_UPD;
            ST_DONE:  if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and multiplier requests
    always_comb begin
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        zx_next      = zx_reg;
        zy_next      = zy_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        iter_next    = iter_reg;
        hue_next     = hue_reg;
        esc_next     = esc_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mul_req      = '{op_a: zx_reg, op_b: zx_reg, mode: MUL_SQR};
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                dx_next   = {1'b0, s_item.pixel_x} - {1'b0, cfg.image_width[SizeBits-1:1]};
                dy_next   = {1'b0, s_item.pixel_y} - {1'b0, cfg.image_height[SizeBits-1:1]};
                iter_next = '0;
                hue_next  = '0;
            end
            ST_MAP_X: begin
                mul_req = '{op_a: CoordBits'(dx_reg), op_b: step_op, mode: MUL_RAW};
            end
            ST_MAP_Y: begin
                mul_req = '{op_a: CoordBits'(dy_reg), op_b: step_op, mode: MUL_RAW};
                cx_next = map_val;
                zx_next = map_val;
            end
            ST_SQ_X0: begin
                mul_req = '{op_a: cx_reg, op_b: cx_reg, mode: MUL_SQR};
                cy_next = map_val;
                zy_next = map_val;
            end
            ST_SQ_Y0: begin
                mul_req = '{op_a: zy_reg, op_b: zy_reg, mode: MUL_SQR};
                sx_next = prod_sat;
            end
            ST_XY: begin
                mul_req = '{op_a: zx_reg, op_b: zy_reg, mode: MUL_DBL};
                sy_next = prod_sat;
            end
            ST_UPD: begin
                zx_next = nx;
                zy_next = ny;
                if (at_limit) begin
                    esc_next = 1'b0;
                end
            end
            ST_SQX: begin
                mul_req = '{op_a: zx_reg, op_b: zx_reg, mode: MUL_SQR};
            end
            ST_SQY: begin
                mul_req = '{op_a: zy_reg, op_b: zy_reg, mode: MUL_SQR};
                sx_next = prod_sat;
            end
            ST_CHK: begin
                mul_req = '{op_a: zx_reg, op_b: zy_reg, mode: MUL_DBL};
                sy_next = prod_sat;
                if (escape_hit) begin
                    esc_next = 1'b1;
                end else begin
                    iter_next = iter_reg + 1'b1;
                    hue_next  = (hue_reg == HueMod - 1'b1) ? '0 : hue_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_item_next.iterations = iter_reg;
                    m_item_next.escaped    = esc_reg;
                    m_item_next.hue        = esc_reg ? hue_reg : '0;
                    m_valid_next           = 1'b1;
                end
            end
            default: begin
                mul_req = '{op_a: zx_reg, op_b: zx_reg, mode: MUL_SQR};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        zx_reg     <= zx_next;
        zy_reg     <= zy_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        iter_reg   <= iter_next;
        hue_reg    <= hue_next;
        esc_reg    <= esc_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `MET_ASSERT(a_black_at_limit, m_valid_reg && !m_item_reg.escaped |-> m_item_reg.iterations == cfg.iter_max, "black item count differs from iteration limit")
    `MET_ASSERT(a_escape_below_limit, m_valid_reg && m_item_reg.escaped |-> m_item_reg.iterations < cfg.iter_max, "escaped item count not below limit")
    `MET_ASSERT(a_count_bounded, state_reg == ST_UPD |-> iter_reg <= cfg.iter_max && hue_reg < HueMod, "round counter past limit")
    `MET_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_valid_reg, "result valid after reset")

endmodule

@@ rtl/mandelbrot_escape_time.sv @@
// Mandelbrot escape-time evaluator: one pixel item in, one result item out.
// Input channel s_valid/s_ready/s_item carries pixel_x and pixel_y. Result channel
// m_valid/m_ready/m_item carries iterations, escaped and hue.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the seven view
// registers (width, height, step, center x/y, iteration limit, escape radius); it is
// always ready; it is to be written only while no item is in flight, which the block
// itself does not enforce. An unused index is ignored. One item is worked at a time
// through a single shared 32x32 multiplier: the pixel mapping and first squares run
// through MAP_X, MAP_Y, SQ_X0, SQ_Y0 and XY, and each orbit round runs through UPD,
// SQX, SQY and CHK (three products, one per cycle, plus the update).
// s_ready is high only while idle, from the cycle after the result is registered
// until the next item is taken.
// The result sits in an output register: while the receiver stalls, the next item is
// still taken and worked, and only its final hand-off waits for the register to drain.
// Synchronous active-low reset returns the view registers to their defaults, drops m_valid
// and leaves the block ready for an item.
module mandelbrot_escape_time import met_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IdxBits-1:0]     cfg_index,
    input  logic [CfgDataBits-1:0] cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item
);

    cfg_t                        cfg;
    mul_req_t                    mul_req;
    logic [ProdBits-1:0]         prod;
    logic                        prod_neg;
    logic signed [CoordBits-1:0] prod_sat;

    met_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    met_mul u_mul (
        .aclk     (aclk),
        .req      (mul_req),
        .prod     (prod),
        .prod_neg (prod_neg),
        .prod_sat (prod_sat)
    );

    met_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .mul_req  (mul_req),
        .prod     (prod),
        .prod_neg (prod_neg),
        .prod_sat (prod_sat)
    );

endmodule

@@ sim/mandelbrot_escape_time_tb.sv @@
// self-checking testbench of mandelbrot_escape_time: directed table, then random views
// depends on rtl/met_pkg.sv and rtl/mandelbrot_escape_time.sv; checks against an internal Q4.28 model
module mandelbrot_escape_time_tb;
    import met_pkg::*;

    localparam logic [IdxBits-1:0] CFG_UNUSED = 3'd7;
    localparam longint CoordMax = 64'sd2147483647;
    localparam longint CoordMin = -64'sd2147483648;
    localparam logic [31:0] RadiusFour = 32'h4000_0000;

    typedef struct packed {
        bit                 is_reg;
        logic [IdxBits-1:0] idx;
        logic [31:0]        data;
        in_item_t           px;
        bit                 known;
        out_item_t          want;
    } plan_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IdxBits-1:0]     cfg_index = '0;
    logic [CfgDataBits-1:0] cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_item = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_item;

    cfg_t view = '{ResetImageWidth, ResetImageHeight, ResetPixelStep, ResetCenter,
                   ResetCenter, ResetIterMax, ResetEscapeRadius};
    out_item_t   pending_escapes[$];
    int unsigned errors = 0;
    int unsigned random_items = 0;
    int unsigned stall_left = 0;
    bit          tx_gap_on = 1'b1;
    bit          rx_stall_on = 1'b1;

    mandelbrot_escape_time dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #5 aclk = ~aclk;

    initial begin
        #100_000_000;
        $display("mandelbrot_escape_time_tb: errors");
        $finish;
    end

    function automatic longint clamp_coord(longint v);
        if (v > CoordMax) begin
            return CoordMax;
        end
        if (v < CoordMin) begin
            return CoordMin;
        end
        return v;
    endfunction

    // product shifted right by sh, truncated toward zero, then saturated
    function automatic longint mul_q(longint a, longint b, int sh);
        bit     neg;
        longint m;
        longint lim;
        neg = (a < 0) != (b < 0);
        m = (a < 0 ? -a : a) * (b < 0 ? -b : b);
        m = m >>> sh;
        lim = neg ? CoordMax + 1 : CoordMax;
        if (m > lim) begin
            m = lim;
        end
        return neg ? -m : m;
    endfunction

    function automatic longint map_axis(logic [PixBits-1:0] pix, logic [SizeBits-1:0] size,
                                        logic signed [CoordBits-1:0] ctr);
        longint p;
        longint h;
        longint s;
        longint c;
        p = pix;
        h = size >> 1;
        s = view.pixel_step;
        c = ctr;
        return clamp_coord((p - h) * s + c);
    endfunction

    function automatic out_item_t escape_time(in_item_t px);
        longint      cx, cy, zx, zy, sx, sy, nx, ny, rad;
        int unsigned n;
        int unsigned lim;
        bit          esc;
        bit          done;
        out_item_t   res;
        cx = map_axis(px.pixel_x, view.image_width, view.center_x);
        cy = map_axis(px.pixel_y, view.image_height, view.center_y);
        rad = view.escape_radius;
        lim = view.iter_max;
        zx = cx;
        zy = cy;
        n = 0;
        esc = 1'b0;
        done = 1'b0;
        while (!done) begin
            sx = mul_q(zx, zx, FracBits);
            sy = mul_q(zy, zy, FracBits);
            nx = clamp_coord(clamp_coord(sx - sy) + cx);
            ny = clamp_coord(mul_q(zx, zy, FracBits - 1) + cy);
            zx = nx;
            zy = ny;
            if (n >= lim) begin
                done = 1'b1;
            end else begin
                sx = mul_q(zx, zx, FracBits);
                sy = mul_q(zy, zy, FracBits);
                if (sx + sy > rad) begin
                    esc = 1'b1;
                    done = 1'b1;
                end else begin
                    n++;
                end
            end
        end
        res.iterations = n[IterBits-1:0];
        res.escaped = esc;
        res.hue = esc ? 8'(n % HueMod) : '0;
        return res;
    endfunction

    function automatic int unsigned pick_gap(bit on);
        int unsigned r;
        if (!on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (rx_stall_on && $urandom_range(0, 2) == 0) begin
                stall_left <= pick_gap(1'b1);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_escapes.size() == 0) begin
                report_mismatch($sformatf("result with nothing due, iterations %0d",
                                          m_item.iterations));
            end else begin
                want = pending_escapes.pop_front();
                if (m_item.iterations !== want.iterations) begin
                    report_mismatch($sformatf("iterations got %0d expected %0d",
                                              m_item.iterations, want.iterations));
                end
                if (m_item.escaped !== want.escaped) begin
                    report_mismatch($sformatf("escaped got %0d expected %0d",
                                              m_item.escaped, want.escaped));
                end
                if (m_item.hue !== want.hue) begin
                    report_mismatch($sformatf("hue got %0d expected %0d",
                                              m_item.hue, want.hue));
                end
            end
        end
    end

    task automatic write_reg(logic [IdxBits-1:0] idx, logic [31:0] data);
        s_valid <= 1'b0;
        while (pending_escapes.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_IMAGE_WIDTH:   view.image_width = data[SizeBits-1:0];
            CFG_IMAGE_HEIGHT:  view.image_height = data[SizeBits-1:0];
            CFG_PIXEL_STEP:    view.pixel_step = data[StepBits-1:0];
            CFG_CENTER_X:      view.center_x = data;
            CFG_CENTER_Y:      view.center_y = data;
            CFG_ITER_MAX:      view.iter_max = data[IterBits-1:0];
            CFG_ESCAPE_RADIUS: view.escape_radius = data;
            default: ;
        endcase
    endtask

    task automatic send_pixel(in_item_t px, bit known, out_item_t want);
        int unsigned gap;
        gap = pick_gap(tx_gap_on);
        cfg_valid <= 1'b0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_escapes.push_back(known ? want : escape_time(px));
    endtask

    function automatic plan_row_t reg_row(logic [IdxBits-1:0] idx, logic [31:0] data);
        plan_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic plan_row_t pixel_row(int x, int y);
        plan_row_t r;
        r = '0;
        r.px.pixel_x = x[PixBits-1:0];
        r.px.pixel_y = y[PixBits-1:0];
        return r;
    endfunction

    function automatic plan_row_t known_row(int x, int y, int iters, bit esc, int hue);
        plan_row_t r;
        r = pixel_row(x, y);
        r.known = 1'b1;
        r.want.iterations = iters[IterBits-1:0];
        r.want.escaped = esc;
        r.want.hue = hue[HueBits-1:0];
        return r;
    endfunction

    // one view setting followed by a burst of pixels
    task automatic random_phase();
        int unsigned kind;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        in_item_t    px;
        kind = $urandom_range(0, 99);
        tx_gap_on = $urandom_range(0, 4) != 0;
        rx_stall_on = $urandom_range(0, 4) != 0;
        if (kind < 85) begin
            w = $urandom_range(4, 256);
            h = $urandom_range(4, 256);
            write_reg(CFG_IMAGE_WIDTH, w);
            write_reg(CFG_IMAGE_HEIGHT, h);
            write_reg(CFG_PIXEL_STEP, (32'd805306368 / w) >> $urandom_range(0, 3));
            write_reg(CFG_CENTER_X, $urandom_range(0, 671088640) - 32'd536870912);
            write_reg(CFG_CENTER_Y, $urandom_range(0, 536870912) - 32'd268435456);
            write_reg(CFG_ITER_MAX, kind < 70 ? $urandom_range(1, 48) : $urandom_range(240, 600));
            write_reg(CFG_ESCAPE_RADIUS, $urandom_range(0, 3) != 0 ? RadiusFour : $urandom);
        end else begin
            for (int i = 0; i < 7; i++) begin
                write_reg(i[IdxBits-1:0], i == CFG_ITER_MAX ? $urandom_range(0, 40) : $urandom);
            end
        end
        if ($urandom_range(0, 1) != 0) begin
            write_reg(CFG_UNUSED, $urandom);
        end
        n = $urandom_range(15, 45);
        repeat (n) begin
            if (kind < 85 && $urandom_range(0, 99) < 85) begin
                px.pixel_x = PixBits'($urandom_range(0, view.image_width - 1));
                px.pixel_y = PixBits'($urandom_range(0, view.image_height - 1));
            end else begin
                px.pixel_x = PixBits'($urandom_range(0, 4095));
                px.pixel_y = PixBits'($urandom_range(0, 4095));
            end
            send_pixel(px, 1'b0, '0);
        end
        random_items += n;
    endtask

    initial begin : stimulus
        plan_row_t plan[$];
        plan = '{
            known_row(320, 240, 255, 1'b0, 0),
            pixel_row(0, 0),
            pixel_row(4095, 4095),
            pixel_row(639, 479),
            pixel_row(160, 300),
            reg_row(CFG_ITER_MAX, 32'd0),
            known_row(100, 100, 0, 1'b0, 0),
            known_row(4095, 0, 0, 1'b0, 0),
            // zero radius: anything but the origin escapes on the first round
            reg_row(CFG_ITER_MAX, 32'hFFFF_FFFF),
            reg_row(CFG_ESCAPE_RADIUS, 32'd0),
            known_row(320, 240, 65535, 1'b0, 0),
            pixel_row(321, 240),
            // full radius is out of reach of two saturated squares
            reg_row(CFG_ESCAPE_RADIUS, 32'hFFFF_FFFF),
            reg_row(CFG_ITER_MAX, 32'd3),
            known_row(0, 0, 3, 1'b0, 0),
            // saturating pixel mapping
            reg_row(CFG_PIXEL_STEP, 32'hFFFF_FFFF),
            reg_row(CFG_CENTER_X, 32'h8000_0000),
            reg_row(CFG_CENTER_Y, 32'h7FFF_FFFF),
            reg_row(CFG_ESCAPE_RADIUS, RadiusFour),
            reg_row(CFG_ITER_MAX, 32'd20),
            pixel_row(0, 0),
            pixel_row(4095, 4095),
            pixel_row(320, 240),
            reg_row(CFG_IMAGE_WIDTH, 32'd0),
            reg_row(CFG_IMAGE_HEIGHT, 32'hFFFF_FFFF),
            reg_row(CFG_PIXEL_STEP, 32'd0),
            reg_row(CFG_CENTER_X, 32'd0),
            reg_row(CFG_CENTER_Y, 32'd0),
            known_row(4095, 0, 20, 1'b0, 0),
            // one-pixel image, upper data bits dropped
            reg_row(CFG_IMAGE_WIDTH, 32'hFFFF_E001),
            reg_row(CFG_IMAGE_HEIGHT, 32'd1),
            reg_row(CFG_PIXEL_STEP, 32'h0400_0000),
            reg_row(CFG_CENTER_X, 32'hF400_0000),
            reg_row(CFG_ITER_MAX, 32'd300),
            reg_row(CFG_UNUSED, 32'hFFFF_FFFF),
            pixel_row(0, 0),
            pixel_row(1, 1),
            pixel_row(3, 2),
            pixel_row(4095, 4095),
            // slow escapes near the neck, counts around the hue wrap
            reg_row(CFG_IMAGE_WIDTH, 32'd0),
            reg_row(CFG_IMAGE_HEIGHT, 32'd0),
            reg_row(CFG_PIXEL_STEP, 32'h0004_0000),
            reg_row(CFG_ITER_MAX, 32'd1000),
            pixel_row(0, 11),
            pixel_row(0, 12),
            pixel_row(0, 13)
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_pixel(plan[i].px, plan[i].known, plan[i].want);
            end
        end
        while (random_items < 450) begin
            random_phase();
        end
        s_valid <= 1'b0;
        while (pending_escapes.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("mandelbrot_escape_time_tb: clean");
        end else begin
            $display("mandelbrot_escape_time_tb: errors");
        end
        $finish;
    end

endmodule

@@ mandelbrot_escape_time.f @@
+incdir+rtl
rtl/met_pkg.sv
rtl/met_cfg.sv
rtl/met_mul.sv
rtl/met_ctrl.sv
rtl/mandelbrot_escape_time.sv
sim/mandelbrot_escape_time_tb.sv
